[design/cpfsk_pkg.sv]
package cpfsk_pkg;

    // phase accumulator and quarter-wave table geometry
    localparam int PHASE_BITS = 16;
    localparam int TBL_AW     = PHASE_BITS - 2;
    localparam int TBL_DEPTH  = 1 << TBL_AW;
    localparam int MAG_W      = 15;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int FSTEP_W    = 15;
    localparam int AMP_W      = 15;
    localparam int SPS_CFG_W  = 7;

    localparam logic [FSTEP_W-1:0]   FREQ_STEP_RST = 15'd2048;
    localparam logic [AMP_W-1:0]     AMPLITUDE_RST = 15'd32767;
    localparam logic [SPS_CFG_W-1:0] SPS_RST       = 7'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQ_STEP = 2'd0,
        CFG_AMPLITUDE = 2'd1,
        CFG_SPS       = 2'd2
    } cfg_idx_t;

    // symbol byte that moves the phase up
    localparam logic [7:0] SYM_UP = 8'd1;

    // q62 fixed point constants for the table generator
    localparam logic [63:0]  Q62_ONE     = 64'h4000_0000_0000_0000;
    localparam logic [63:0]  Q62_HALF_PI = 64'h6487_ED51_10B4_611A;
    localparam logic [127:0] ROT_X  = {64'b0, (Q62_HALF_PI >> TBL_AW)};
    localparam logic [127:0] ROT_X2 = (ROT_X * ROT_X) >> 62;
    localparam logic [127:0] ROT_X3 = (ROT_X2 * ROT_X) >> 62;
    localparam logic [127:0] ROT_X4 = (ROT_X2 * ROT_X2) >> 62;
    localparam logic [127:0] ROT_X5 = (ROT_X4 * ROT_X) >> 62;
    localparam logic [127:0] ROT_COS_W = {64'b0, Q62_ONE} - ROT_X2 / 2 + ROT_X4 / 24;
    localparam logic [127:0] ROT_SIN_W = ROT_X - ROT_X3 / 6 + ROT_X5 / 120;
    // cos and sin of one table step, q62
    localparam logic [63:0]  ROT_COS = ROT_COS_W[63:0];
    localparam logic [63:0]  ROT_SIN = ROT_SIN_W[63:0];

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

    // partial product groups of one rotation step
    typedef enum logic [1:0] {
        T_CC = 2'd0,
        T_SS = 2'd1,
        T_SC = 2'd2,
        T_CS = 2'd3
    } mac_term_t;

    typedef enum logic {
        FILL_RUN  = 1'b0,
        FILL_DONE = 1'b1
    } fill_state_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } back_state_t;

    typedef struct packed {
        logic              we;
        logic [TBL_AW-1:0] addr;
        logic [MAG_W-1:0]  cos_mag;
        logic [MAG_W-1:0]  sin_mag;
    } tbl_wr_t;

endpackage

[design/cpfsk_modulator.sv]
// channel  dir  handshake            payload
// s_       in   s_tvalid, s_tready   s_tdata[7:0] symbol
// m_       out  m_tvalid, m_tready   m_tdata[15:0] i_sample, [31:16] q_sample, m_tlast
// cfg_     in   cfg_wr_en            cfg_index, cfg_wdata (write only)
//
// one sample per cycle while m_tready is high and the back end holds a symbol;
// a symbol gives samples_per_symbol samples, counted by the back-end sample
// counter and read through the single table read port. after pickup a sample passes
// the state, table read, product and output registers. after reset the quarter-wave
// table is generated, 16384 entries, with s_tready low; config writes still land.
// a 2-word queue sits between symbol intake and sample generation, so
// s_tready stays high while the output is stalled until the queue fills.
module cpfsk_modulator #(
    parameter int MAX_SPS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // symbol input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] symbol
    // sample output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // [15:0] i_sample, [31:16] q_sample
    output logic                             m_tlast,   // last_sample
    // register writes
    input  logic                             cfg_wr_en,
    input  logic [cpfsk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpfsk_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import cpfsk_pkg::*;

    localparam int SPS_W = (MAX_SPS > 1) ? $clog2(MAX_SPS) : 1;

    logic [FSTEP_W-1:0]   freq_step_reg;
    logic [AMP_W-1:0]     amplitude_reg;
    logic [SPS_CFG_W-1:0] sps_cfg_reg;

    logic                 fill_done;
    tbl_wr_t              tbl_wr;
    logic                 push, q_full, q_valid, q_pop;
    logic [SPS_W:0]       push_data, q_data;

    // configuration registers, indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_step_reg <= FREQ_STEP_RST;
            amplitude_reg <= AMPLITUDE_RST;
            sps_cfg_reg   <= SPS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FREQ_STEP: freq_step_reg <= cfg_wdata[FSTEP_W-1:0];
                CFG_AMPLITUDE: amplitude_reg <= cfg_wdata[AMP_W-1:0];
                CFG_SPS:       sps_cfg_reg   <= cfg_wdata[SPS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // symbol intake: direction and clamped symbol length
    cpfsk_front #(
        .MAX_SPS (MAX_SPS)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .sps_cfg   (sps_cfg_reg),
        .fill_done (fill_done),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    cpfsk_queue #(
        .DATA_W (SPS_W + 1)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_data)
    );

    // quarter-wave cos/sin generator, runs once after reset
    cpfsk_rom_init u_rom_init (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tbl_wr    (tbl_wr),
        .fill_done (fill_done)
    );

    // phase accumulator, table lookup, amplitude scaling
    cpfsk_back #(
        .MAX_SPS (MAX_SPS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .freq_step (freq_step_reg),
        .amplitude (amplitude_reg),
        .tbl_wr    (tbl_wr),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[design/cpfsk_front.sv]
module cpfsk_front #(
    parameter int  MAX_SPS = 64,
    localparam int SPS_W   = (MAX_SPS > 1) ? $clog2(MAX_SPS) : 1
) (
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // symbol
    input  logic [cpfsk_pkg::SPS_CFG_W-1:0]  sps_cfg,
    input  logic                             fill_done,
    input  logic                             q_full,
    output logic                             push,
    output logic [SPS_W:0]                   push_data  // {up, sps_m1}
);
    import cpfsk_pkg::*;

    logic [8:0]       sps_ext;
    logic [8:0]       sps_clamp;
    logic [8:0]       sps_m1_full;
    logic             up;

    assign s_tready = fill_done && !q_full;
    assign push     = s_tvalid && s_tready;
    assign up       = (s_tdata == SYM_UP);

    // zero means one, above the cap saturates
    always_comb begin
        sps_ext = 9'(sps_cfg);
        if (sps_ext == 9'd0) begin
            sps_clamp = 9'd1;
        end else if (sps_ext > 9'(MAX_SPS)) begin
            sps_clamp = 9'(MAX_SPS);
        end else begin
            sps_clamp = sps_ext;
        end
        sps_m1_full = sps_clamp - 9'd1;
    end

    assign push_data = {up, sps_m1_full[SPS_W-1:0]};

endmodule

[design/cpfsk_queue.sv]
module cpfsk_queue #(
    parameter int DATA_W = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/cpfsk_rom_init.sv]
module cpfsk_rom_init (
    input  logic               aclk,
    input  logic               aresetn,
    output cpfsk_pkg::tbl_wr_t tbl_wr,
    output logic               fill_done
);
    import cpfsk_pkg::*;

    localparam logic [4:0] STEP_MAC_LAST = 5'd15;
    localparam logic [4:0] STEP_UPDATE   = 5'd17;
    localparam logic [TBL_AW-1:0] ADDR_LAST = TBL_AW'(TBL_DEPTH - 1);

    fill_state_t       state_reg, state_next;
    logic [4:0]        step_reg, step_next;
    logic [TBL_AW-1:0] addr_reg;
    logic [63:0]       c_reg, s_reg;
    logic [127:0]      acc_c_reg, acc_c_next;
    logic [127:0]      acc_s_reg, acc_s_next;
    logic [63:0]       prod_reg;
    mac_term_t         prod_term_reg;
    logic [1:0]        prod_sh_reg;
    logic              prod_v_reg;

    mac_term_t         term;
    logic [63:0]       op_a, op_b;
    logic [31:0]       a_part, b_part;
    logic [127:0]      addend;
    logic              running;

    // round(32767 * v) from the q42 truncation of a q62 value
    function automatic logic [MAG_W-1:0] q15_round(input logic [63:0] v);
        logic [57:0] q42;
        logic [57:0] prod;
        q42  = 58'(v[62:20]);
        prod = (q42 << 15) - q42 + (58'd1 << 41);
        return prod[56:42];
    endfunction

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FILL_RUN: begin
                if (step_reg == 5'd0 && addr_reg == ADDR_LAST) begin
                    state_next = FILL_DONE;
                end
            end
            FILL_DONE: state_next = FILL_DONE;
            default:   state_next = FILL_RUN;
        endcase
    end

    // outputs
    always_comb begin
        running        = (state_reg == FILL_RUN);
        fill_done      = (state_reg == FILL_DONE);
        tbl_wr.we      = running && (step_reg == 5'd0);
        tbl_wr.addr    = addr_reg;
        tbl_wr.cos_mag = q15_round(c_reg);
        tbl_wr.sin_mag = q15_round(s_reg);
    end

    // operand select for one 32x32 partial product
    always_comb begin
        term = mac_term_t'(step_reg[3:2]);
        case (term)
            T_CC: begin op_a = c_reg; op_b = ROT_COS; end
            T_SS: begin op_a = s_reg; op_b = ROT_SIN; end
            T_SC: begin op_a = s_reg; op_b = ROT_COS; end
            T_CS: begin op_a = c_reg; op_b = ROT_SIN; end
            default: begin op_a = c_reg; op_b = ROT_COS; end
        endcase
        a_part = step_reg[1] ? op_a[63:32] : op_a[31:0];
        b_part = step_reg[0] ? op_b[63:32] : op_b[31:0];
    end

    // accumulate c' = c*C - s*S and s' = s*C + c*S
    always_comb begin
        addend     = {64'b0, prod_reg} << {prod_sh_reg, 5'b0};
        acc_c_next = acc_c_reg;
        acc_s_next = acc_s_reg;
        if (prod_v_reg) begin
            case (prod_term_reg)
                T_CC:    acc_c_next = acc_c_reg + addend;
                T_SS:    acc_c_next = acc_c_reg - addend;
                T_SC:    acc_s_next = acc_s_reg + addend;
                T_CS:    acc_s_next = acc_s_reg + addend;
                default: acc_c_next = acc_c_reg;
            endcase
        end
        step_next = (step_reg == STEP_UPDATE) ? 5'd0 : step_reg + 5'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= FILL_RUN;
            step_reg   <= 5'd0;
            addr_reg   <= '0;
            c_reg      <= Q62_ONE;
            s_reg      <= '0;
            acc_c_reg  <= '0;
            acc_s_reg  <= '0;
            prod_v_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            prod_v_reg <= running && (step_reg <= STEP_MAC_LAST);
            if (running) begin
                step_reg <= step_next;
                if (step_reg == STEP_UPDATE) begin
                    c_reg     <= acc_c_reg[125:62];
                    s_reg     <= acc_s_reg[125:62];
                    acc_c_reg <= '0;
                    acc_s_reg <= '0;
                    addr_reg  <= addr_reg + 1'b1;
                end else begin
                    acc_c_reg <= acc_c_next;
                    acc_s_reg <= acc_s_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg      <= 64'(a_part) * 64'(b_part);
        prod_term_reg <= term;
        prod_sh_reg   <= {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
    end

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= STEP_UPDATE)
        else $error("table generator step out of range");

    a_done_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(fill_done) |-> ($past(addr_reg) == ADDR_LAST))
        else $error("table fill finished before the last entry");

    a_mag_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        !c_reg[63] && !s_reg[63])
        else $error("rotation state left the unit range");

endmodule

[design/cpfsk_back.sv]
module cpfsk_back #(
    parameter int  MAX_SPS = 64,
    localparam int SPS_W   = (MAX_SPS > 1) ? $clog2(MAX_SPS) : 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  logic [SPS_W:0]                 q_data,   // {up, sps_m1}
    output logic                           q_pop,
    input  logic [cpfsk_pkg::FSTEP_W-1:0]  freq_step,
    input  logic [cpfsk_pkg::AMP_W-1:0]    amplitude,
    input  cpfsk_pkg::tbl_wr_t             tbl_wr,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,  // i_sample, q_sample
    output logic                           m_tlast
);
    import cpfsk_pkg::*;

    back_state_t            state_reg, state_next;
    logic                   up_reg;
    logic [SPS_W-1:0]       sps_m1_reg;
    logic [SPS_W-1:0]       cnt_reg;
    logic [PHASE_BITS-1:0]  phase_reg, phase_next;

    logic [2*MAG_W-1:0]     tbl_mem [TBL_DEPTH];
    logic [2*MAG_W-1:0]     rd_reg;
    logic                   v1_reg, last1_reg;
    quad_t                  quad1_reg;
    logic                   v2_reg, last2_reg;
    logic signed [31:0]     i_prod_reg, q_prod_reg;
    logic                   out_v_reg, out_last_reg;
    logic [15:0]            i_out_reg, q_out_reg;

    logic                   en, gen, last_now;
    logic signed [15:0]     cos_s, sin_s, ci, si, amp_s;

    assign en       = !out_v_reg || m_tready;
    assign last_now = (cnt_reg == sps_m1_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (q_valid) state_next = BK_RUN;
            BK_RUN:  if (gen && last_now && !q_valid) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        gen   = (state_reg == BK_RUN) && en;
        q_pop = q_valid && ((state_reg == BK_IDLE) || (gen && last_now));
    end

    always_comb begin
        if (up_reg) begin
            phase_next = phase_reg + PHASE_BITS'(freq_step);
        end else begin
            phase_next = phase_reg - PHASE_BITS'(freq_step);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            phase_reg <= '0;
            cnt_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_pop) begin
                cnt_reg <= '0;
            end else if (gen) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (gen) begin
                phase_reg <= phase_next;
            end
            if (en) begin
                v1_reg    <= gen;
                v2_reg    <= v1_reg;
                out_v_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            up_reg     <= q_data[SPS_W];
            sps_m1_reg <= q_data[SPS_W-1:0];
        end
    end

    // quarter-wave table: written by the generator, read once per sample
    always_ff @(posedge aclk) begin
        if (tbl_wr.we) begin
            tbl_mem[tbl_wr.addr] <= {tbl_wr.cos_mag, tbl_wr.sin_mag};
        end
        if (en) begin
            rd_reg <= tbl_mem[phase_next[TBL_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quad1_reg <= quad_t'(phase_next[PHASE_BITS-1 -: 2]);
            last1_reg <= last_now;
        end
    end

    // quadrant fold
    always_comb begin
        cos_s = $signed({1'b0, rd_reg[2*MAG_W-1:MAG_W]});
        sin_s = $signed({1'b0, rd_reg[MAG_W-1:0]});
        amp_s = $signed({1'b0, amplitude});
        case (quad1_reg)
            QUAD_I:   begin ci = cos_s;  si = sin_s;  end
            QUAD_II:  begin ci = -sin_s; si = cos_s;  end
            QUAD_III: begin ci = -cos_s; si = -sin_s; end
            QUAD_IV:  begin ci = sin_s;  si = -cos_s; end
            default:  begin ci = cos_s;  si = sin_s;  end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            i_prod_reg   <= ci * amp_s;
            q_prod_reg   <= si * amp_s;
            last2_reg    <= last1_reg;
            // floor of product / 2^15
            i_out_reg    <= i_prod_reg[30:15];
            q_out_reg    <= q_prod_reg[30:15];
            out_last_reg <= last2_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {q_out_reg, i_out_reg};
    assign m_tlast  = out_last_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_RUN) |-> (cnt_reg <= sps_m1_reg))
        else $error("sample count beyond symbol length");

    a_pop_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_RUN && q_pop) |-> (gen && last_now))
        else $error("new symbol taken before the current one ended");

    a_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (gen && last_now) |=> ((state_reg == BK_IDLE) || (cnt_reg == '0)))
        else $error("counter did not restart after the last sample");

endmodule

[bench/tb.sv]
module tb;
    import cpfsk_pkg::*;

    // clock and run limits
    localparam int CLK_HALF       = 10;
    localparam int MAX_SPS        = 64;
    // the timeout covers table generation and the stimulus
    localparam int TIMEOUT_CYCLES = 5_000_000;
    // register index that the block has no register behind
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // random symbols per configuration segment
    localparam int SEG_SYMBOLS    = 28;

    // one output word as the checker sees it
    typedef struct {
        logic signed [15:0] i_val;
        logic signed [15:0] q_val;
        logic               last;
    } iq_sample_t;

    // directed stimulus: a register write or a symbol, optionally with a typed-in result
    typedef enum logic {
        ROW_WRITE  = 1'b0,
        ROW_SYMBOL = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  val;
        logic [7:0]             sym;
        bit                     typed;
        logic signed [15:0]     exp_i;
        logic signed [15:0]     exp_q;
        logic                   exp_last;
    } dir_row_t;

    localparam int N_ROWS = 35;

    // phase comments give the accumulator after the row
    dir_row_t directed_rows [N_ROWS] = '{
        // reset values: step 2048, full amplitude, 8 samples per symbol
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     SYM_UP, 1'b0, 16'sd0,     16'sd0,     1'b0}, // 16384
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     8'd0,   1'b0, 16'sd0,     16'sd0,     1'b0}, // 0
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     8'd255, 1'b0, 16'sd0,     16'sd0,     1'b0}, // 49152
        // quarter-turn steps, one sample per symbol: axis points are exact
        '{ROW_WRITE,  CFG_SPS,       15'd1,     8'd0,   1'b0, 16'sd0,     16'sd0,     1'b0},
        '{ROW_WRITE,  CFG_FREQ_STEP, 15'd16384, 8'd0,   1'b0, 16'sd0,     16'sd0,     1'b0},
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     SYM_UP, 1'b1, 16'sd32766, 16'sd0,     1'b1}, // wrap up
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     8'd0,   1'b1, 16'sd0,     -16'sd32767, 1'b1}, // wrap down
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     SYM_UP, 1'b1, 16'sd32766, 16'sd0,     1'b1}, // 0
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     SYM_UP, 1'b1, 16'sd0,     16'sd32766, 1'b1}, // 16384
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     SYM_UP, 1'b1, -16'sd32767, 16'sd0,    1'b1}, // 32768
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     8'd254, 1'b1, 16'sd0,     16'sd32766, 1'b1}, // 16384
        // zero amplitude silences both rails
        '{ROW_WRITE,  CFG_AMPLITUDE, 15'd0,     8'd0,   1'b0, 16'sd0,     16'sd0,     1'b0},
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     SYM_UP, 1'b1, 16'sd0,     16'sd0,     1'b1}, // 32768
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     8'd128, 1'b1, 16'sd0,     16'sd0,     1'b1}, // 16384
        // zero step holds the phase
        '{ROW_WRITE,  CFG_AMPLITUDE, 15'd32767, 8'd0,   1'b0, 16'sd0,     16'sd0,     1'b0},
        '{ROW_WRITE,  CFG_FREQ_STEP, 15'd0,     8'd0,   1'b0, 16'sd0,     16'sd0,     1'b0},
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     SYM_UP, 1'b1, 16'sd0,     16'sd32766, 1'b1},
        // zero samples per symbol behaves as one
        '{ROW_WRITE,  CFG_SPS,       15'd0,     8'd0,   1'b0, 16'sd0,     16'sd0,     1'b0},
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     8'd2,   1'b1, 16'sd0,     16'sd32766, 1'b1},
        // largest step
        '{ROW_WRITE,  CFG_FREQ_STEP, 15'd32767, 8'd0,   1'b0, 16'sd0,     16'sd0,     1'b0},
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     SYM_UP, 1'b0, 16'sd0,     16'sd0,     1'b0},
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     8'd0,   1'b0, 16'sd0,     16'sd0,     1'b0},
        // oversized sample count saturates, then the exact maximum
        '{ROW_WRITE,  CFG_SPS,       15'd127,   8'd0,   1'b0, 16'sd0,     16'sd0,     1'b0},
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     SYM_UP, 1'b0, 16'sd0,     16'sd0,     1'b0},
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     8'd64,  1'b0, 16'sd0,     16'sd0,     1'b0},
        '{ROW_WRITE,  CFG_SPS,       15'd64,    8'd0,   1'b0, 16'sd0,     16'sd0,     1'b0},
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     SYM_UP, 1'b0, 16'sd0,     16'sd0,     1'b0},
        // write to an unused index must change nothing
        '{ROW_WRITE,  CFG_SPARE,     15'h7FFF,  8'd0,   1'b0, 16'sd0,     16'sd0,     1'b0},
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     8'd129, 1'b0, 16'sd0,     16'sd0,     1'b0},
        // tiny amplitude, odd step
        '{ROW_WRITE,  CFG_AMPLITUDE, 15'd1,     8'd0,   1'b0, 16'sd0,     16'sd0,     1'b0},
        '{ROW_WRITE,  CFG_FREQ_STEP, 15'd12345, 8'd0,   1'b0, 16'sd0,     16'sd0,     1'b0},
        '{ROW_WRITE,  CFG_SPS,       15'd3,     8'd0,   1'b0, 16'sd0,     16'sd0,     1'b0},
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     SYM_UP, 1'b0, 16'sd0,     16'sd0,     1'b0},
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     8'd170, 1'b0, 16'sd0,     16'sd0,     1'b0},
        '{ROW_SYMBOL, CFG_FREQ_STEP, 15'd0,     8'd85,  1'b0, 16'sd0,     16'sd0,     1'b0}
    };

    // dut ports, the driven ones known from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'd0;   // [7:0] symbol
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;            // [15:0] i_sample, [31:16] q_sample
    logic                  m_tlast;            // last_sample
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // modulator state as the checker tracks it
    logic [FSTEP_W-1:0]    mod_step  = FREQ_STEP_RST;
    logic [AMP_W-1:0]      mod_amp   = AMPLITUDE_RST;
    logic [SPS_CFG_W-1:0]  mod_sps   = SPS_RST;
    logic [PHASE_BITS-1:0] mod_phase = '0;

    // samples still owed by the block, oldest first
    iq_sample_t expected_samples[$];
    int         mismatch_count = 0;

    // idle odds in percent per cycle
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    cpfsk_modulator #(
        .MAX_SPS(MAX_SPS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 20 unit period
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // sample predictor
    // ---------------------------------------------------------------

    // q62 times q62, truncated back to q62
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // q62 fraction in [0, 1] to round(32767 * v), half away from zero
    function automatic longint round_to_q15(input logic [63:0] v);
        logic [63:0] q42;
        q42 = v >> 20;
        return longint'((q42 * 64'd32767 + (64'd1 << 41)) >> 42);
    endfunction

    // cos and sin magnitudes inside one quadrant by taylor series in q62
    task automatic quarter_wave_mag(input logic [TBL_AW-1:0] r,
                                    output longint cmag, output longint smag);
        logic [127:0] wide;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        int           n;
        wide = {64'd0, Q62_HALF_PI} * {{(128 - TBL_AW){1'b0}}, r};
        x    = wide[TBL_AW + 63:TBL_AW];
        x2   = q62_mul(x, x);

        term = Q62_ONE;
        sum  = Q62_ONE;
        for (n = 2; n <= 28; n += 2) begin
            term = q62_mul(term, x2) / 64'((n - 1) * n);
            if ((n & 2) != 0) sum = sum - term;
            else sum = sum + term;
        end
        cmag = round_to_q15(sum);

        term = x;
        sum  = x;
        for (n = 3; n <= 29; n += 2) begin
            term = q62_mul(term, x2) / 64'((n - 1) * n);
            if (((n - 1) & 2) != 0) sum = sum - term;
            else sum = sum + term;
        end
        smag = round_to_q15(sum);
    endtask

    // amplitude scaling, floor division by 2^15
    function automatic logic signed [15:0] scale_by_amplitude(input longint t, input longint amp);
        longint p;
        p = t * amp;
        if (p >= 0) return 16'(p >>> 15);
        return 16'(-((-p + 32767) >>> 15));
    endfunction

    // step the phase once per sample; with phase_only set nothing is queued
    task automatic predict_samples(input logic [7:0] sym, input bit phase_only);
        logic [SPS_CFG_W-1:0] count;
        quad_t                quad;
        longint               c;
        longint               s;
        longint               ci;
        longint               si;
        iq_sample_t           smp;
        bit                   up;
        int                   k;
        up    = (sym == SYM_UP);
        count = mod_sps;
        if (count == 0) count = 1;
        if (count > MAX_SPS) count = SPS_CFG_W'(MAX_SPS);
        for (k = 0; k < count; k++) begin
            if (up) mod_phase = mod_phase + mod_step;
            else mod_phase = mod_phase - mod_step;
            if (!phase_only) begin
                quad = quad_t'(mod_phase[PHASE_BITS-1:PHASE_BITS-2]);
                quarter_wave_mag(mod_phase[TBL_AW-1:0], c, s);
                case (quad)
                    QUAD_I: begin
                        ci = c;
                        si = s;
                    end
                    QUAD_II: begin
                        ci = -s;
                        si = c;
                    end
                    QUAD_III: begin
                        ci = -c;
                        si = -s;
                    end
                    default: begin
                        ci = s;
                        si = -c;
                    end
                endcase
                smp.i_val = scale_by_amplitude(ci, mod_amp);
                smp.q_val = scale_by_amplitude(si, mod_amp);
                smp.last  = (k + 1 == count);
                expected_samples.push_back(smp);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // offer one symbol word, idling first at random; expectations are
    // queued at the accepting edge, well ahead of the first sample
    task automatic send_symbol(input logic [7:0] sym, input bit typed,
                               input iq_sample_t typed_res);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            s_tdata  = 8'($urandom);
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = sym;
        do @(posedge aclk); while (!s_tready);
        // typed rows only move the phase here and supply their own result
        predict_samples(sym, typed);
        if (typed) expected_samples.push_back(typed_res);
    endtask

    // hold off the sender until every owed sample is out, plus the pipe depth
    task automatic drain_pipeline();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // registers change only with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain_pipeline();
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(posedge aclk);
        case (idx)
            CFG_FREQ_STEP: mod_step = val[FSTEP_W-1:0];
            CFG_AMPLITUDE: mod_amp  = val[AMP_W-1:0];
            CFG_SPS:       mod_sps  = val[SPS_CFG_W-1:0];
            default: ;   // unused index, dropped by the block
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        cfg_wdata = '0;
    endtask

    // receiver back-pressure, redrawn every cycle
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= sink_idle_pct);
    end

    // ---------------------------------------------------------------
    // output checker: each accepted sample word against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        iq_sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected sample word: i_sample %0d q_sample %0d last_sample %0b",
                       $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tlast);
                mismatch_count++;
            end else begin
                want = expected_samples.pop_front();
                if (m_tdata[15:0] !== want.i_val) begin
                    $error("i_sample: expected %0d, got %0d", want.i_val,
                           $signed(m_tdata[15:0]));
                    mismatch_count++;
                end
                if (m_tdata[31:16] !== want.q_val) begin
                    $error("q_sample: expected %0d, got %0d", want.q_val,
                           $signed(m_tdata[31:16]));
                    mismatch_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_sample: expected %0b, got %0b", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    initial begin
        iq_sample_t           typed_res;
        logic [CFG_DATA_W-1:0] step_val;
        logic [CFG_DATA_W-1:0] amp_val;
        logic [CFG_DATA_W-1:0] sps_val;
        logic [7:0]            sym;
        int                    row;
        int                    ph;
        int                    seg;
        int                    item;

        // reset once
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table, no idling; the first symbol waits out table generation
        for (row = 0; row < N_ROWS; row++) begin
            if (directed_rows[row].kind == ROW_WRITE) begin
                write_reg(directed_rows[row].idx, directed_rows[row].val);
            end else begin
                typed_res.i_val = directed_rows[row].exp_i;
                typed_res.q_val = directed_rows[row].exp_q;
                typed_res.last  = directed_rows[row].exp_last;
                send_symbol(directed_rows[row].sym, directed_rows[row].typed, typed_res);
            end
        end

        // random part: three idling patterns, three register settings each
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct  = 31;
                    sink_idle_pct = 71;
                end
                1: begin
                    src_idle_pct  = 71;
                    sink_idle_pct = 31;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (seg = 0; seg < 3; seg++) begin
                case ($urandom_range(4))
                    0:       step_val = 15'h7FFF;
                    1:       step_val = 15'($urandom_range(1, 64));
                    default: step_val = 15'($urandom);
                endcase
                case ($urandom_range(3))
                    0:       amp_val = 15'h7FFF;
                    1:       amp_val = 15'($urandom_range(0, 3));
                    default: amp_val = 15'($urandom);
                endcase
                // mostly short symbols, now and then the saturating corners
                case ($urandom_range(19))
                    12, 13, 14: sps_val = 15'($urandom_range(9, 64));
                    15:         sps_val = 15'd0;
                    16:         sps_val = 15'd64;
                    17:         sps_val = 15'($urandom_range(65, 127));
                    18, 19:     sps_val = 15'd1;
                    default:    sps_val = 15'($urandom_range(1, 8));
                endcase
                write_reg(CFG_FREQ_STEP, step_val);
                write_reg(CFG_AMPLITUDE, amp_val);
                write_reg(CFG_SPS, sps_val);
                if ($urandom_range(3) == 0) write_reg(CFG_SPARE, 15'($urandom));
                for (item = 0; item < SEG_SYMBOLS; item++) begin
                    case ($urandom_range(3))
                        0, 1:    sym = SYM_UP;
                        2:       sym = 8'($urandom);
                        default: sym = 8'($urandom_range(0, 2));
                    endcase
                    send_symbol(sym, 1'b0, typed_res);
                end
            end
        end

        // let the last samples out, then wait on for strays
        drain_pipeline();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && expected_samples.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // hard stop if the block hangs
    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
design/cpfsk_pkg.sv
design/cpfsk_front.sv
design/cpfsk_queue.sv
design/cpfsk_rom_init.sv
design/cpfsk_back.sv
design/cpfsk_modulator.sv
bench/tb.sv
